// ----- hw/rtl/infix_integer_expression_evaluator_unit_macros.svh -----
// Assertion macros shared by the RTL.
// Each macro takes a label, clock, active-low reset, antecedent and consequent.
`ifndef INFIX_INTEGER_EXPRESSION_EVALUATOR_UNIT_MACROS_SVH
`define INFIX_INTEGER_EXPRESSION_EVALUATOR_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define IIEE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication
`define IIEE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: check failed");

`else

`define IIEE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define IIEE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/iiee_pkg.sv -----
package iiee_pkg;

	// datapath width and derived sizes
	localparam int VALUE_WIDTH = 32;
	localparam int OUT_W       = 32;
	localparam int EXT_W       = 64;
	localparam int CH_W        = 8;
	localparam int DIGIT_W     = 4;
	localparam int CNT_W       = $clog2(VALUE_WIDTH);

	// character codes
	localparam logic [CH_W-1:0] CH_0     = 8'h30;
	localparam logic [CH_W-1:0] CH_9     = 8'h39;
	localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [CH_W-1:0] CH_EQ    = 8'h3D;

	// operator waiting inside the current term
	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_MUL  = 2'd1;
	localparam logic [1:0] PEND_DIV  = 2'd2;

	// microprogram addresses
	localparam int UPC_W = 4;
	localparam logic [UPC_W-1:0] UPC_IDLE    = 4'd0;
	localparam logic [UPC_W-1:0] UPC_DIGIT   = 4'd1;
	localparam logic [UPC_W-1:0] UPC_APPLY   = 4'd2;
	localparam logic [UPC_W-1:0] UPC_MUL     = 4'd3;
	localparam logic [UPC_W-1:0] UPC_DIVINIT = 4'd4;
	localparam logic [UPC_W-1:0] UPC_DIVZERO = 4'd5;
	localparam logic [UPC_W-1:0] UPC_DIVSTEP = 4'd6;
	localparam logic [UPC_W-1:0] UPC_DIVFIX  = 4'd7;
	localparam logic [UPC_W-1:0] UPC_FINISH  = 4'd8;
	localparam logic [UPC_W-1:0] UPC_EMIT    = 4'd9;

	// jump conditions
	localparam int JMP_W = 3;
	localparam logic [JMP_W-1:0] JMP_NEXT     = 3'd0;
	localparam logic [JMP_W-1:0] JMP_DISPATCH = 3'd1;
	localparam logic [JMP_W-1:0] JMP_PEND     = 3'd2;
	localparam logic [JMP_W-1:0] JMP_DIVZ     = 3'd3;
	localparam logic [JMP_W-1:0] JMP_LOOP     = 3'd4;
	localparam logic [JMP_W-1:0] JMP_OPKIND   = 3'd5;
	localparam logic [JMP_W-1:0] JMP_OUT      = 3'd6;

	// datapath actions
	localparam int ACT_W = 4;
	localparam logic [ACT_W-1:0] ACT_NOP       = 4'd0;
	localparam logic [ACT_W-1:0] ACT_ACCEPT    = 4'd1;
	localparam logic [ACT_W-1:0] ACT_DIGIT     = 4'd2;
	localparam logic [ACT_W-1:0] ACT_T_NUM     = 4'd3;
	localparam logic [ACT_W-1:0] ACT_T_MUL     = 4'd4;
	localparam logic [ACT_W-1:0] ACT_DIV_START = 4'd5;
	localparam logic [ACT_W-1:0] ACT_T_ZERO    = 4'd6;
	localparam logic [ACT_W-1:0] ACT_DIV_STEP  = 4'd7;
	localparam logic [ACT_W-1:0] ACT_T_DIV     = 4'd8;
	localparam logic [ACT_W-1:0] ACT_FINISH    = 4'd9;
	localparam logic [ACT_W-1:0] ACT_EMIT      = 4'd10;

	typedef struct packed {
		logic [UPC_W-1:0] nxt;
		logic [JMP_W-1:0] jmp;
		logic [ACT_W-1:0] act;
	} ucode_t;

	// divider control from the sequencer
	typedef struct packed {
		logic start;
		logic step;
	} div_ctl_t;

	// control store
	function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
		ucode_t w;
		case (addr)
			UPC_IDLE:    w = '{nxt: UPC_APPLY,   jmp: JMP_DISPATCH, act: ACT_ACCEPT};
			UPC_DIGIT:   w = '{nxt: UPC_IDLE,    jmp: JMP_NEXT,     act: ACT_DIGIT};
			UPC_APPLY:   w = '{nxt: UPC_FINISH,  jmp: JMP_PEND,     act: ACT_T_NUM};
			UPC_MUL:     w = '{nxt: UPC_FINISH,  jmp: JMP_NEXT,     act: ACT_T_MUL};
			UPC_DIVINIT: w = '{nxt: UPC_DIVSTEP, jmp: JMP_DIVZ,     act: ACT_DIV_START};
			UPC_DIVZERO: w = '{nxt: UPC_FINISH,  jmp: JMP_NEXT,     act: ACT_T_ZERO};
			UPC_DIVSTEP: w = '{nxt: UPC_DIVFIX,  jmp: JMP_LOOP,     act: ACT_DIV_STEP};
			UPC_DIVFIX:  w = '{nxt: UPC_FINISH,  jmp: JMP_NEXT,     act: ACT_T_DIV};
			UPC_FINISH:  w = '{nxt: UPC_IDLE,    jmp: JMP_OPKIND,   act: ACT_FINISH};
			UPC_EMIT:    w = '{nxt: UPC_IDLE,    jmp: JMP_OUT,      act: ACT_EMIT};
			default:     w = '{nxt: UPC_IDLE,    jmp: JMP_NEXT,     act: ACT_NOP};
		endcase
		return w;
	endfunction

	// character classes
	function automatic logic is_digit(input logic [CH_W-1:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_op(input logic [CH_W-1:0] c);
		return (c == CH_STAR) || (c == CH_SLASH) || (c == CH_PLUS) ||
			(c == CH_MINUS) || (c == CH_EQ);
	endfunction

	// sign-extend the datapath value and keep the low output bits
	function automatic logic [OUT_W-1:0] to_out(input logic [VALUE_WIDTH-1:0] v);
		logic [EXT_W-1:0] w;
		w = EXT_W'(signed'(v));
		return w[OUT_W-1:0];
	endfunction

endpackage

// ----- hw/rtl/iiee_div.sv -----
module iiee_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  iiee_pkg::div_ctl_t                ctl,
	input  logic [iiee_pkg::VALUE_WIDTH-1:0]  dividend,
	input  logic [iiee_pkg::VALUE_WIDTH-1:0]  divisor,
	output logic [iiee_pkg::VALUE_WIDTH-1:0]  quotient,
	output logic                              last
);

	logic [iiee_pkg::VALUE_WIDTH-1:0] rem_q;
	logic [iiee_pkg::VALUE_WIDTH-1:0] quo_q;
	logic [iiee_pkg::VALUE_WIDTH-1:0] dsr_q;
	logic                             neg_q;
	logic [iiee_pkg::CNT_W-1:0]       cnt_q;
	logic [iiee_pkg::VALUE_WIDTH:0]   trial;
	logic                             fits;

	// one restoring step: shift in the next dividend bit and try a subtract
	assign trial = {rem_q, quo_q[iiee_pkg::VALUE_WIDTH-1]} - {1'b0, dsr_q};
	assign fits  = !trial[iiee_pkg::VALUE_WIDTH];

	// iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.start) begin
			cnt_q <= iiee_pkg::CNT_W'(iiee_pkg::VALUE_WIDTH - 1);
		end else if (ctl.step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// magnitudes in, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			neg_q <= dividend[iiee_pkg::VALUE_WIDTH-1] ^ divisor[iiee_pkg::VALUE_WIDTH-1];
			quo_q <= dividend[iiee_pkg::VALUE_WIDTH-1] ? -dividend : dividend;
			dsr_q <= divisor[iiee_pkg::VALUE_WIDTH-1] ? -divisor : divisor;
			rem_q <= '0;
		end else if (ctl.step) begin
			rem_q <= fits ? trial[iiee_pkg::VALUE_WIDTH-1:0]
				: {rem_q[iiee_pkg::VALUE_WIDTH-2:0], quo_q[iiee_pkg::VALUE_WIDTH-1]};
			quo_q <= {quo_q[iiee_pkg::VALUE_WIDTH-2:0], fits};
		end
	end

	// truncating quotient, sign restored
	assign quotient = neg_q ? -quo_q : quo_q;
	assign last     = (cnt_q == '0);

endmodule

// ----- hw/rtl/infix_integer_expression_evaluator_unit.sv -----
// Channel   Handshake             Payload
// input     in_valid / in_stall   ch (8b character)
// output    out_valid / out_stall value (32b signed), div_by_zero
//
// A microcoded sequencer takes one request in its idle step, then runs:
// digit DIGIT; + - = or * / with no operator pending APPLY, FINISH; after * APPLY,
// MUL, FINISH; after / APPLY, DIVINIT, DIVSTEP (one quotient bit a cycle), DIVFIX,
// FINISH; after / by zero APPLY, DIVINIT, DIVZERO, FINISH; '=' adds EMIT.
// arst_n clears the sequencer, the expression state and the output valid flag.
// A waiting result sits in the output register; the next request is taken meanwhile,
// and only a second '=' waits for out_stall to drop.
`include "infix_integer_expression_evaluator_unit_macros.svh"

module infix_integer_expression_evaluator_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [iiee_pkg::CH_W-1:0]   ch,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [iiee_pkg::OUT_W-1:0]  value,
	output logic                        div_by_zero
);

	logic [iiee_pkg::UPC_W-1:0]       upc_q;
	logic [iiee_pkg::UPC_W-1:0]       upc_nxt;
	iiee_pkg::ucode_t                 uc;
	logic [iiee_pkg::CH_W-1:0]        ch_q;
	logic [iiee_pkg::VALUE_WIDTH-1:0] total_q;
	logic [iiee_pkg::VALUE_WIDTH-1:0] term_q;
	logic [iiee_pkg::VALUE_WIDTH-1:0] number_q;
	logic [iiee_pkg::VALUE_WIDTH-1:0] t_q;
	logic                             neg_q;
	logic [1:0]                       pend_q;
	logic                             err_q;
	logic                             out_valid_q;
	logic [iiee_pkg::OUT_W-1:0]       value_q;
	logic                             dz_q;
	logic                             accept;
	logic                             out_room;
	logic                             emit;
	logic [iiee_pkg::VALUE_WIDTH-1:0] prod_lo;
	logic [iiee_pkg::VALUE_WIDTH-1:0] number_ext;
	logic [iiee_pkg::DIGIT_W-1:0]     digit;
	iiee_pkg::div_ctl_t               div_ctl;
	logic [iiee_pkg::VALUE_WIDTH-1:0] quotient;
	logic                             div_last;

	// control word for this step
	assign uc       = iiee_pkg::ucode_rom(upc_q);
	assign in_stall = (upc_q != iiee_pkg::UPC_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_room = !out_valid_q || !out_stall;
	assign emit     = (uc.act == iiee_pkg::ACT_EMIT) && out_room;

	// sequencer: next address
	always_comb begin
		upc_nxt = uc.nxt;
		case (uc.jmp)
			iiee_pkg::JMP_NEXT: begin
				upc_nxt = uc.nxt;
			end
			iiee_pkg::JMP_DISPATCH: begin
				if (!in_valid) begin
					upc_nxt = upc_q;
				end else if (iiee_pkg::is_digit(ch)) begin
					upc_nxt = iiee_pkg::UPC_DIGIT;
				end else if (iiee_pkg::is_op(ch)) begin
					upc_nxt = uc.nxt;
				end else begin
					upc_nxt = upc_q;
				end
			end
			iiee_pkg::JMP_PEND: begin
				if (pend_q == iiee_pkg::PEND_MUL) begin
					upc_nxt = iiee_pkg::UPC_MUL;
				end else if (pend_q == iiee_pkg::PEND_DIV) begin
					upc_nxt = iiee_pkg::UPC_DIVINIT;
				end else begin
					upc_nxt = uc.nxt;
				end
			end
			iiee_pkg::JMP_DIVZ: begin
				upc_nxt = (number_q == '0) ? iiee_pkg::UPC_DIVZERO : uc.nxt;
			end
			iiee_pkg::JMP_LOOP: begin
				upc_nxt = div_last ? uc.nxt : upc_q;
			end
			iiee_pkg::JMP_OPKIND: begin
				upc_nxt = (ch_q == iiee_pkg::CH_EQ) ? iiee_pkg::UPC_EMIT : uc.nxt;
			end
			iiee_pkg::JMP_OUT: begin
				upc_nxt = out_room ? uc.nxt : upc_q;
			end
			default: begin
				upc_nxt = iiee_pkg::UPC_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= iiee_pkg::UPC_IDLE;
		end else begin
			upc_q <= upc_nxt;
		end
	end

	// request character
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q <= ch;
		end
	end

	// operand helpers; the product keeps only the low word
	assign digit      = iiee_pkg::DIGIT_W'(ch_q - iiee_pkg::CH_0);
	assign number_ext = iiee_pkg::VALUE_WIDTH'(digit);
	assign prod_lo    = term_q * number_q;

	// divider
	assign div_ctl.start = (uc.act == iiee_pkg::ACT_DIV_START);
	assign div_ctl.step  = (uc.act == iiee_pkg::ACT_DIV_STEP);

	iiee_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (term_q),
		.divisor  (number_q),
		.quotient (quotient),
		.last     (div_last)
	);

	// combined operand of the finished factor
	always_ff @(posedge clk) begin
		case (uc.act)
			iiee_pkg::ACT_T_NUM:  t_q <= number_q;
			iiee_pkg::ACT_T_MUL:  t_q <= prod_lo;
			iiee_pkg::ACT_T_ZERO: t_q <= '0;
			iiee_pkg::ACT_T_DIV:  t_q <= quotient;
			default:              t_q <= t_q;
		endcase
	end

	// expression state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			term_q   <= '0;
			number_q <= '0;
			neg_q    <= 1'b0;
			pend_q   <= iiee_pkg::PEND_NONE;
			err_q    <= 1'b0;
		end else begin
			case (uc.act)
				iiee_pkg::ACT_DIGIT: begin
					number_q <= {number_q[iiee_pkg::VALUE_WIDTH-4:0], 3'b000}
						+ {number_q[iiee_pkg::VALUE_WIDTH-2:0], 1'b0} + number_ext;
				end
				iiee_pkg::ACT_T_ZERO: begin
					err_q <= 1'b1;
				end
				iiee_pkg::ACT_FINISH: begin
					number_q <= '0;
					if (ch_q == iiee_pkg::CH_STAR || ch_q == iiee_pkg::CH_SLASH) begin
						term_q <= t_q;
						pend_q <= (ch_q == iiee_pkg::CH_STAR) ? iiee_pkg::PEND_MUL
							: iiee_pkg::PEND_DIV;
					end else begin
						total_q <= neg_q ? (total_q - t_q) : (total_q + t_q);
						term_q  <= '0;
						pend_q  <= iiee_pkg::PEND_NONE;
						neg_q   <= (ch_q == iiee_pkg::CH_MINUS);
					end
				end
				iiee_pkg::ACT_EMIT: begin
					if (out_room) begin
						total_q  <= '0;
						term_q   <= '0;
						number_q <= '0;
						neg_q    <= 1'b0;
						pend_q   <= iiee_pkg::PEND_NONE;
						err_q    <= 1'b0;
					end
				end
				default: begin
					total_q <= total_q;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			value_q <= iiee_pkg::to_out(total_q);
			dz_q    <= err_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign value       = value_q;
	assign div_by_zero = dz_q;

	// checks
	`IIEE_ASSERT_NXT(a_emit_loads_out, clk, arst_n, emit, out_valid)
	`IIEE_ASSERT_NXT(a_emit_clears, clk, arst_n, emit,
		total_q == '0 && err_q == 1'b0 && number_q == '0)
	`IIEE_ASSERT_NXT(a_div_exit, clk, arst_n,
		upc_q == iiee_pkg::UPC_DIVSTEP && div_last, upc_q == iiee_pkg::UPC_DIVFIX)
	`IIEE_ASSERT_NXT(a_idle_holds, clk, arst_n,
		upc_q == iiee_pkg::UPC_IDLE && !in_valid, upc_q == iiee_pkg::UPC_IDLE)

endmodule

// ----- tb/infix_integer_expression_evaluator_unit_tb.sv -----
`timescale 1ns / 100ps

module infix_integer_expression_evaluator_unit_tb;
	import iiee_pkg::*;

	localparam int RANDOM_ITEMS   = 1800;
	localparam int LATENCY_CYCLES = 64;
	localparam int HOLD_CYCLES    = 400;
	localparam int CYCLE_LIMIT    = 1000000;
	localparam int DIR_ROWS       = 9;

	// one character request, with a typed expectation on a directed '='
	typedef struct {
		logic [CH_W-1:0]  code;
		bit               fixed;
		logic [OUT_W-1:0] val;
		bit               dz;
	} char_req_t;

	typedef struct packed {
		logic [OUT_W-1:0] val;
		logic             dz;
	} result_t;

	// directed row: expression text and, where fixed, its typed result
	typedef struct {
		string            text;
		bit               fixed;
		logic [OUT_W-1:0] val;
		bit               dz;
	} dir_row_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	logic [CH_W-1:0]     ch        = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [OUT_W-1:0]    value;
	logic                div_by_zero;

	char_req_t char_q[$];
	result_t   result_q[$];
	char_req_t cur_req;
	int        item_cnt     = 0;
	int        mismatch_cnt = 0;
	int        burst_left   = 0;
	bit        hold_req     = 1'b0;

	// directed table
	dir_row_t dir_tab [0:DIR_ROWS-1] = '{
		'{"=",                      1'b1, 32'd0,        1'b0},
		'{"9/0=",                   1'b1, 32'd0,        1'b1},
		'{"-7=",                    1'b1, -32'sd7,      1'b0},
		'{"2+3 *4-8/3\377=",        1'b1, 32'd12,       1'b0},
		'{"2147483648/4294967295=", 1'b1, 32'h8000_0000, 1'b0},
		'{"4294967295+1=",          1'b1, 32'd0,        1'b0},
		'{"12*34/5-6*7=",           1'b0, 32'd0,        1'b0},
		'{"-100/7+3*-2=",           1'b0, 32'd0,        1'b0},
		'{"99999999999*3/0+5=",     1'b0, 32'd0,        1'b0}
	};

	// evaluator state kept by the testbench
	logic [VALUE_WIDTH-1:0] acc_total  = '0;
	logic [VALUE_WIDTH-1:0] acc_term   = '0;
	logic [VALUE_WIDTH-1:0] acc_number = '0;
	logic                   acc_neg    = 1'b0;
	logic [1:0]             acc_pend   = PEND_NONE;
	logic                   acc_err    = 1'b0;

	infix_integer_expression_evaluator_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.ch          (ch),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.value       (value),
		.div_by_zero (div_by_zero)
	);

	always #1 clk = ~clk;

	// run guard
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("infix_integer_expression_evaluator_unit test failed");
		$finish;
	end

	function automatic bit is_active_char(input logic [CH_W-1:0] c);
		return (c >= CH_0 && c <= CH_9) || c == CH_PLUS || c == CH_MINUS ||
			c == CH_STAR || c == CH_SLASH || c == CH_EQ;
	endfunction

	// signed quotient, truncated toward zero, divisor known non-zero
	function automatic logic [VALUE_WIDTH-1:0] quot_trunc(input logic [VALUE_WIDTH-1:0] a,
			input logic [VALUE_WIDTH-1:0] b);
		logic [VALUE_WIDTH-1:0] ma, mb, q;
		ma = a[VALUE_WIDTH-1] ? -a : a;
		mb = b[VALUE_WIDTH-1] ? -b : b;
		q  = ma / mb;
		return (a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1]) ? -q : q;
	endfunction

	// advance the evaluator state by one character
	task automatic eval_char(input logic [CH_W-1:0] c, output bit emit,
			output logic [OUT_W-1:0] res, output bit dz);
		logic [VALUE_WIDTH-1:0] t;
		emit = 1'b0;
		res  = '0;
		dz   = 1'b0;
		if (c >= CH_0 && c <= CH_9) begin
			acc_number = acc_number * 10 + VALUE_WIDTH'(c - CH_0);
		end else if (is_active_char(c)) begin
			// fold the number just read into the term
			case (acc_pend)
				PEND_MUL: t = acc_term * acc_number;
				PEND_DIV: begin
					if (acc_number == '0) begin
						t = '0;
						acc_err = 1'b1;
					end else begin
						t = quot_trunc(acc_term, acc_number);
					end
				end
				default: t = acc_number;
			endcase
			acc_number = '0;
			if (c == CH_STAR || c == CH_SLASH) begin
				acc_term = t;
				acc_pend = (c == CH_STAR) ? PEND_MUL : PEND_DIV;
			end else begin
				acc_total = acc_neg ? acc_total - t : acc_total + t;
				acc_term  = '0;
				acc_pend  = PEND_NONE;
				acc_neg   = (c == CH_MINUS);
				if (c == CH_EQ) begin
					emit       = 1'b1;
					res        = OUT_W'(acc_total);
					dz         = acc_err;
					acc_total  = '0;
					acc_neg    = 1'b0;
					acc_err    = 1'b0;
				end
			end
		end
	endtask

	task automatic report(input string what, input logic [OUT_W-1:0] ev, input bit ed);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("%0t: %s: expected value=%0d dz=%0b, got value=%0d dz=%0b",
				$realtime, what, $signed(ev), ed, $signed(value), div_by_zero);
	endtask

	// result check, then prediction for the request taken at this edge
	always @(posedge clk) begin : scoreboard
		bit emit, dz;
		logic [OUT_W-1:0] res;
		result_t r;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					report("unexpected result", '0, 1'b0);
				end else begin
					r = result_q.pop_front();
					if (value !== r.val || div_by_zero !== r.dz)
						report("result mismatch", r.val, r.dz);
				end
			end
			if (in_valid && !in_stall) begin
				eval_char(ch, emit, res, dz);
				if (emit) begin
					if (cur_req.fixed)
						result_q.push_back('{val: cur_req.val, dz: cur_req.dz});
					else
						result_q.push_back('{val: res, dz: dz});
				end
			end
		end
	end

	// receiver: changing stall patterns plus a long hold-off on request
	initial begin : receiver
		int mode, mode_left, hold_cnt;
		bit hold_taken;
		mode_left  = 0;
		hold_cnt   = 0;
		hold_taken = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_cnt   = HOLD_CYCLES;
			end else if (!hold_req) begin
				hold_taken = 1'b0;
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(10, 200);
			end
			mode_left--;
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else begin
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ((mode_left % 8) < 3);
				endcase
			end
		end
	end

	task automatic push_code(input logic [CH_W-1:0] c, input bit fixed = 1'b0,
			input logic [OUT_W-1:0] v = '0, input bit dz = 1'b0);
		char_q.push_back('{code: c, fixed: fixed, val: v, dz: dz});
		item_cnt++;
	endtask

	task automatic push_text(input string s, input bit fixed = 1'b0,
			input logic [OUT_W-1:0] v = '0, input bit dz = 1'b0);
		for (int i = 0; i < s.len(); i++)
			push_code(s[i], fixed && (i == s.len() - 1), v, dz);
	endtask

	function automatic logic [CH_W-1:0] noise_char();
		logic [CH_W-1:0] c;
		case ($urandom_range(0, 5))
			0: c = 8'h00;
			1: c = 8'hFF;
			2: c = " ";
			default: begin
				c = CH_W'($urandom_range(0, 255));
				while (is_active_char(c))
					c = CH_W'($urandom_range(0, 255));
			end
		endcase
		return c;
	endfunction

	// decimal operand: mostly short, some extremes and some that overflow
	function automatic string number_text();
		string s;
		case ($urandom_range(0, 15))
			0, 1, 2, 3, 4, 5: s = $sformatf("%0d", $urandom_range(0, 9));
			6, 7, 8, 9:       s = $sformatf("%0d", $urandom_range(0, 999));
			10, 11:           s = $sformatf("%0d", 32'($urandom()));
			12: begin
				case ($urandom_range(0, 3))
					0: s = "0";
					1: s = "2147483647";
					2: s = "2147483648";
					default: s = "4294967295";
				endcase
			end
			13: s = $sformatf("00%0d", $urandom_range(0, 99));
			14: begin
				s = "";
				repeat ($urandom_range(11, 13))
					s = $sformatf("%s%0d", s, $urandom_range(0, 9));
			end
			default: s = $sformatf("%0d", $urandom_range(0, 99999));
		endcase
		return s;
	endfunction

	// one random expression: usually well formed, sometimes a broken fragment
	task automatic gen_expression();
		string pool;
		int nterms, nfact;
		bit after_div;
		pool = "0123456789+-*/= ";
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 8)) begin
				if ($urandom_range(0, 3) == 0)
					push_code(noise_char());
				else
					push_code(pool[$urandom_range(0, 15)]);
			end
		end else begin
			if ($urandom_range(0, 7) == 0)
				push_code(CH_MINUS);
			nterms = $urandom_range(1, 4);
			for (int t = 0; t < nterms; t++) begin
				if (t > 0)
					push_code($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
				nfact     = $urandom_range(1, 3);
				after_div = 1'b0;
				for (int f = 0; f < nfact; f++) begin
					if (f > 0) begin
						after_div = ($urandom_range(0, 1) == 1);
						push_code(after_div ? CH_SLASH : CH_STAR);
					end
					if ($urandom_range(0, 11) == 0)
						push_code(noise_char());
					if ($urandom_range(0, 15) == 0)
						continue;
					if (after_div && $urandom_range(0, 5) == 0)
						push_text("0");
					else
						push_text(number_text());
					if ($urandom_range(0, 11) == 0)
						push_code(noise_char());
				end
			end
			push_code(CH_EQ);
		end
	endtask

	// sender: bursts of back-to-back requests with random gaps
	task automatic send_req(input char_req_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			case ($urandom_range(0, 9))
				0, 1, 2, 3:    gap = 0;
				4, 5, 6, 7:    gap = $urandom_range(1, 4);
				default:       gap = $urandom_range(5, 30);
			endcase
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		cur_req = r;
		in_valid <= 1'b1;
		ch       <= r.code;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_queued();
		while (char_q.size() != 0)
			send_req(char_q.pop_front());
	endtask

	// stop offering and wait until every result is back and the block is quiet
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (result_q.size() != 0) @(negedge clk);
		repeat (LATENCY_CYCLES) @(negedge clk);
	endtask

	// receiver holds off while short expressions keep coming
	task automatic pressure();
		hold_req   = 1'b1;
		burst_left = 1000;
		repeat (12) push_text("1=");
		send_queued();
		hold_req   = 1'b0;
		burst_left = 0;
	endtask

	initial begin : main
		bit mid_done;
		mid_done = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table: typed expectations where they are obvious
		for (int i = 0; i < DIR_ROWS; i++)
			push_text(dir_tab[i].text, dir_tab[i].fixed, dir_tab[i].val, dir_tab[i].dz);
		send_queued();
		drain();
		pressure();

		// random expressions
		while (item_cnt < RANDOM_ITEMS) begin
			gen_expression();
			send_queued();
			if (!mid_done && item_cnt >= RANDOM_ITEMS / 2) begin
				mid_done = 1'b1;
				drain();
				pressure();
			end
		end
		drain();

		if (mismatch_cnt == 0 && result_q.size() == 0)
			$display("infix_integer_expression_evaluator_unit test passed");
		else
			$display("infix_integer_expression_evaluator_unit test failed");
		$finish;
	end

endmodule
